// ===== src/assert_macros.svh =====
// Assertion macros used by the rate limiter top level.
// Depends on nothing; the including module must have i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/psprl_pkg.sv =====
// Types and constants of the per-source post rate limiter.
// Used by the request interface and all RTL modules; depends on nothing.
package psprl_pkg;

    localparam int ADDR_W = 32;
    localparam int TIME_W = 48;
    localparam int CFG_W  = 32;

    localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = 32'd1000000;

    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_POST  = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] tstamp;
    } t_record;

    // Expiry limit: now_time minus min_interval, with the borrow kept apart.
    typedef struct packed {
        logic              neg;
        logic [TIME_W-1:0] value;
    } t_limit;

    typedef struct packed {
        logic expired;
        logic hit;
    } t_cmp_res;

endpackage

// ===== src/psprl_if.sv =====
// Valid/ready channel interfaces of the rate limiter: request and answer words.
// Depends on psprl_pkg.
interface psprl_in_if;
    import psprl_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [ADDR_W-1:0] source_address;
    logic [TIME_W-1:0] now_time;

    modport source (output valid, command, source_address, now_time, input ready);
    modport sink   (input valid, command, source_address, now_time, output ready);
endinterface

interface psprl_out_if;
    logic valid;
    logic ready;
    logic allowed;

    modport source (output valid, allowed, input ready);
    modport sink   (input valid, allowed, output ready);
endinterface

// ===== src/psprl_ring.sv =====
// Record memory of the rate limiter: one write port, one registered read port.
// Depends on psprl_pkg.
module psprl_ring #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_idx,
    input  psprl_pkg::t_record   i_wr_rec,
    input  logic                 i_rd_en,
    input  logic [IDX_W-1:0]     i_rd_idx,
    output psprl_pkg::t_record   o_rd_rec
);
    import psprl_pkg::*;

    t_record r_mem [DEPTH];
    t_record r_rd_rec;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_rec <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_rec = r_rd_rec;

endmodule

// ===== src/psprl_cmp.sv =====
// Shared compare unit: tests one stored record for expiry and address match.
// Depends on psprl_pkg.
module psprl_cmp (
    input  psprl_pkg::t_record            i_rec,
    input  logic [psprl_pkg::ADDR_W-1:0]  i_addr,
    input  psprl_pkg::t_limit             i_lim,
    output psprl_pkg::t_cmp_res           o_res
);
    import psprl_pkg::*;

    // A negative limit means no record can be old enough to expire.
    always_comb begin
        o_res.expired = !i_lim.neg && (i_rec.tstamp < i_lim.value);
        o_res.hit     = (i_rec.addr == i_addr);
    end

endmodule

// ===== src/per_source_post_rate_limiter_top.sv =====
// Top level of the per-source post rate limiter: sequencer, pointers, config.
// Depends on psprl_pkg, psprl_if, psprl_ring, psprl_cmp and assert_macros.svh.
//
// Usage: request words arrive on i_in (command, source_address, now_time).
// A post command stores (address, time) as the newest record of a ring that
// holds DEPTH-1 records, dropping the oldest one when the ring is full. It
// produces no answer word. A check command walks the ring
// from the newest record toward the oldest, one record per cycle, through the
// single read port of the record memory, and sends one answer word on o_out.
// The walk stops at the first record older than now_time - min_interval
// (allowed), at the first record with the same address (denied), or at the
// end of the ring (allowed). A check visits 0 to DEPTH-1 records and takes no
// new word until its answer is in the output register; the next word can be
// taken in the same cycle as the answer shows.
// The answer sits in an output register: if the receiver stalls, the block
// still takes post words and starts the next check, and only waits before
// handing over a second answer. The user must write min_interval through
// i_cfg_wr_en/i_cfg_wr_data only while idle; the block does not enforce it.
// Reset empties the ring, sets min_interval to 1000000; record memory is kept.
`include "assert_macros.svh"

module per_source_post_rate_limiter_top #(
    parameter int DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [psprl_pkg::CFG_W-1:0]  i_cfg_wr_data,
    psprl_in_if.sink                     i_in,
    psprl_out_if.source                  o_out
);
    import psprl_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_WALK    = 2'd1;
    localparam logic [1:0] ST_DELIVER = 2'd2;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - 1'b1;
    endfunction

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_newest, n_newest;
    logic [IDX_W-1:0] r_oldest, n_oldest;
    logic [IDX_W-1:0] r_ptr, n_ptr;
    logic             r_last, n_last;
    logic             r_res, n_res;
    logic             r_out_valid, n_out_valid;
    logic             r_out_allowed, n_out_allowed;
    logic [CFG_W-1:0] r_min_interval;
    logic [ADDR_W-1:0] r_addr;
    t_limit           r_lim;

    logic             in_acc;
    logic             chk_acc;
    logic             post_acc;
    logic             ring_empty;
    logic             out_free;
    logic [TIME_W:0]  lim_diff;
    logic [IDX_W-1:0] newest_next;
    logic [IDX_W-1:0] newest_prev;
    logic [IDX_W-1:0] ptr_prev;

    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] mem_rd_idx;
    t_record          mem_wr_rec;
    t_record          mem_rd_rec;
    t_cmp_res         cmp_res;

    // New words are taken only between walks; the answer register decouples
    // the output side, so a stalled receiver does not block posts.
    assign i_in.ready    = (r_state == ST_IDLE);
    assign in_acc        = i_in.valid && i_in.ready;
    assign chk_acc       = in_acc && (i_in.command == CMD_CHECK);
    assign post_acc      = in_acc && (i_in.command == CMD_POST);
    assign ring_empty    = (r_newest == r_oldest);
    assign out_free      = !r_out_valid || o_out.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.allowed = r_out_allowed;

    // The limit is formed once per check; its borrow marks a negative limit.
    assign lim_diff = {1'b0, i_in.now_time} - {(TIME_W + 1 - CFG_W)'(0), r_min_interval};

    assign newest_next = ring_next(r_newest);
    assign newest_prev = ring_prev(r_newest);
    assign ptr_prev    = ring_prev(r_ptr);

    assign mem_wr_rec.addr   = i_in.source_address;
    assign mem_wr_rec.tstamp = i_in.now_time;

    psprl_ring #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ring (
        .i_clk    (i_clk),
        .i_wr_en  (mem_we),
        .i_wr_idx (newest_next),
        .i_wr_rec (mem_wr_rec),
        .i_rd_en  (mem_re),
        .i_rd_idx (mem_rd_idx),
        .o_rd_rec (mem_rd_rec)
    );

    psprl_cmp u_cmp (
        .i_rec  (mem_rd_rec),
        .i_addr (r_addr),
        .i_lim  (r_lim),
        .o_res  (cmp_res)
    );

    always_comb begin
        n_state       = r_state;
        n_newest      = r_newest;
        n_oldest      = r_oldest;
        n_ptr         = r_ptr;
        n_last        = r_last;
        n_res         = r_res;
        n_out_valid   = r_out_valid;
        n_out_allowed = r_out_allowed;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_rd_idx    = r_ptr;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.command == CMD_POST) begin
                        // The new record goes into the slot after the newest one;
                        // a full ring gives up its oldest record for it.
                        mem_we   = 1'b1;
                        n_newest = newest_next;
                        if (newest_next == r_oldest) begin
                            n_oldest = ring_next(r_oldest);
                        end
                    end else if (r_newest == r_oldest) begin
                        n_res   = 1'b1;
                        n_state = ST_DELIVER;
                    end else begin
                        // Fetch the newest record now; the walk compares it next cycle.
                        mem_re     = 1'b1;
                        mem_rd_idx = r_newest;
                        n_ptr      = newest_prev;
                        n_last     = (newest_prev == r_oldest);
                        n_state    = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                // Compare the record that just came out of memory and fetch the
                // one before it in the same cycle.
                mem_re = 1'b1;
                n_ptr  = ptr_prev;
                n_last = (ptr_prev == r_oldest);
                if (cmp_res.expired) begin
                    n_res   = 1'b1;
                    n_state = ST_DELIVER;
                end else if (cmp_res.hit) begin
                    n_res   = 1'b0;
                    n_state = ST_DELIVER;
                end else if (r_last) begin
                    n_res   = 1'b1;
                    n_state = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_allowed = r_res;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_newest       <= '0;
            r_oldest       <= '0;
            r_out_valid    <= 1'b0;
            r_min_interval <= MIN_INTERVAL_RST;
        end else begin
            r_state     <= n_state;
            r_newest    <= n_newest;
            r_oldest    <= n_oldest;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_min_interval <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr         <= n_ptr;
        r_last        <= n_last;
        r_res         <= n_res;
        r_out_allowed <= n_out_allowed;
        if (chk_acc) begin
            r_addr      <= i_in.source_address;
            r_lim.neg   <= lim_diff[TIME_W];
            r_lim.value <= lim_diff[TIME_W-1:0];
        end
    end

    // A walk only runs over a ring that holds at least one record.
    `ASSERT_CLK(a_walk_nonempty, (r_state == ST_WALK) |-> !ring_empty, "walk on empty ring")
    // A check on an empty ring answers allowed without touching the memory.
    `ASSERT_CLK(a_empty_ok, (chk_acc && ring_empty) |=> (r_res && r_state == ST_DELIVER), "empty check")
    // After a post the ring is never empty.
    `ASSERT_CLK(a_post_fills, post_acc |=> !ring_empty, "ring empty after post")
    // Ring pointers stay inside the memory.
    `ASSERT_CLK(a_ptr_range, (r_newest <= LAST_IDX) && (r_oldest <= LAST_IDX), "bad pointer")
    // An answer is handed over only from the delivery state.
    `ASSERT_CLK(a_answer_src, $rose(r_out_valid) |-> ($past(r_state) == ST_DELIVER), "stray answer")

endmodule
